@@ design/glm4_pkg.sv @@
// ----------------------------------------------------------------------------
// glm4_pkg
// Shared widths, read selects and the command/status bundles that join the
// local maximum controller to its datapath.
// ----------------------------------------------------------------------------
package glm4_pkg;

	localparam int VAL_W   = 32;  // grid element and peak value
	localparam int ROW_W   = 10;  // row position
	localparam int PCOL_W  = 5;   // column field of a result item
	localparam int TOT_W   = 16;  // peak total
	localparam int ROWS_W  = 11;  // grid_rows register
	localparam int COLS_W  = 6;   // grid_cols register
	localparam int CIDX_W  = 1;   // configuration register index
	localparam int CDAT_W  = 11;  // configuration write data
	localparam int SLOT_W  = 2;   // line store slot, row mod 3

	localparam logic [CIDX_W-1:0] REG_ROWS = 1'd0;
	localparam logic [CIDX_W-1:0] REG_COLS = 1'd1;

	typedef logic [1:0] nb_sel_t;
	localparam nb_sel_t NB_CTR   = 2'd0;  // centre element (down compare on capture)
	localparam nb_sel_t NB_UP    = 2'd1;
	localparam nb_sel_t NB_LEFT  = 2'd2;
	localparam nb_sel_t NB_RIGHT = 2'd3;

	typedef struct packed {
		logic    in_load;     // take the input item and write it to the line store
		logic    tgt_in;      // aim the decision at the row above the input
		logic    tgt_flush;   // aim the decision at the first column of the last row
		logic    flush_next;  // step the flush to the next column
		nb_sel_t rd_sel;      // line store read address select
		logic    cap_en;      // read data is valid this cycle
		nb_sel_t cap_sel;     // what the read data is
		logic    emit_peak;   // load a peak item into the output register
		logic    emit_sum;    // load the summary item into the output register
		logic    adv_col;
		logic    adv_row;
		logic    frame_clr;   // return position and peak count to zero
	} glm4_cmd_t;

	typedef struct packed {
		logic has_prev;    // a row above exists and the column is in range
		logic col_last;    // input position sits on the last column
		logic row_last;    // input position sits on the last row
		logic flush_last;  // decision column is the last column
		logic peak_fail;   // a neighbour is greater than the centre
		logic out_free;    // output register can take an item this cycle
	} glm4_sts_t;

	function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		r = (s == 2'd0) ? 2'd2 : s - 2'd1;
		return r;
	endfunction

	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		r = (s == 2'd2) ? 2'd0 : s + 2'd1;
		return r;
	endfunction

endpackage

@@ design/glm4_ram.sv @@
// ----------------------------------------------------------------------------
// glm4_ram
// Generic single write, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module glm4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 96
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/glm4_ctrl.sv @@
// ----------------------------------------------------------------------------
// glm4_ctrl
// Sequencer: accepts an item, walks the four line store reads of each
// decision, emits peaks and runs the frame-end flush and summary.
// ----------------------------------------------------------------------------
module glm4_ctrl
	import glm4_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  glm4_sts_t sts,
	output glm4_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RDC  = 4'd1;
	localparam logic [3:0] ST_RDU  = 4'd2;
	localparam logic [3:0] ST_RDL  = 4'd3;
	localparam logic [3:0] ST_RDR  = 4'd4;
	localparam logic [3:0] ST_RDX  = 4'd5;
	localparam logic [3:0] ST_EMIT = 4'd6;
	localparam logic [3:0] ST_ADV  = 4'd7;
	localparam logic [3:0] ST_SUM  = 4'd8;

	logic [3:0] state_q, state_d;
	logic       flush_q, flush_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		flush_d = flush_q;
		cmd     = '0;
		cmd.rd_sel  = NB_CTR;
		cmd.cap_sel = NB_CTR;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.in_load = 1'b1;
					flush_d     = 1'b0;
					if (sts.has_prev) begin
						cmd.tgt_in = 1'b1;
						state_d    = ST_RDC;
					end else begin
						state_d = ST_ADV;
					end
				end
			end
			ST_RDC: begin
				cmd.rd_sel = NB_CTR;
				state_d    = ST_RDU;
			end
			ST_RDU: begin
				cmd.rd_sel  = NB_UP;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = NB_CTR;
				state_d     = ST_RDL;
			end
			ST_RDL: begin
				cmd.rd_sel  = NB_LEFT;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = NB_UP;
				state_d     = ST_RDR;
			end
			ST_RDR: begin
				cmd.rd_sel  = NB_RIGHT;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = NB_LEFT;
				state_d     = ST_RDX;
			end
			ST_RDX: begin
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = NB_RIGHT;
				state_d     = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.peak_fail || sts.out_free) begin
					cmd.emit_peak = !sts.peak_fail;
					if (!flush_q) begin
						state_d = ST_ADV;
					end else if (sts.flush_last) begin
						state_d = ST_SUM;
					end else begin
						cmd.flush_next = 1'b1;
						state_d        = ST_RDC;
					end
				end
			end
			ST_ADV: begin
				if (sts.col_last && sts.row_last) begin
					cmd.tgt_flush = 1'b1;
					flush_d       = 1'b1;
					state_d       = ST_RDC;
				end else if (sts.col_last) begin
					cmd.adv_row = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.adv_col = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_SUM: begin
				if (sts.out_free) begin
					cmd.emit_sum  = 1'b1;
					cmd.frame_clr = 1'b1;
					flush_d       = 1'b0;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				flush_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			flush_q <= 1'b0;
		end else begin
			state_q <= state_d;
			flush_q <= flush_d;
		end
	end

endmodule

@@ design/glm4_dpath.sv @@
// ----------------------------------------------------------------------------
// glm4_dpath
// Configuration registers, raster position, three-row line store, one shared
// signed comparator, peak counter and the output register.
// ----------------------------------------------------------------------------
module glm4_dpath
	import glm4_pkg::*;
#(
	parameter int MAX_COLS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [CDAT_W-1:0]  cfg_data,
	input  logic [VAL_W-1:0]   cell_value,
	input  glm4_cmd_t          cmd,
	output glm4_sts_t          sts,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [VAL_W-1:0]   peak_value,
	output logic [ROW_W-1:0]   peak_row,
	output logic [PCOL_W-1:0]  peak_col,
	output logic               is_summary,
	output logic [TOT_W-1:0]   peak_total
);

	localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int DEPTH  = 3 * MAX_COLS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_COLS - 1);

	// configuration
	logic [ROWS_W-1:0] grid_rows_q;
	logic [COLS_W-1:0] grid_cols_q;
	logic [ROWS_W-1:0] nrows;
	logic [COLS_W-1:0] ncols;

	// raster position
	logic [ROW_W-1:0]  cur_row_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [SLOT_W-1:0] cur_slot_q;
	logic [TOT_W-1:0]  peaks_q;

	// element under decision
	logic [ROW_W-1:0]  tgt_row_q;
	logic [COL_W-1:0]  tgt_col_q;
	logic [SLOT_W-1:0] tgt_slot_q;
	logic              tgt_down_q;
	logic [VAL_W-1:0]  down_q;
	logic [VAL_W-1:0]  ctr_q;
	logic              fail_q;

	// output register
	logic              out_valid_q;
	logic [VAL_W-1:0]  peak_value_q;
	logic [ROW_W-1:0]  peak_row_q;
	logic [PCOL_W-1:0] peak_col_q;
	logic              is_summary_q;
	logic [TOT_W-1:0]  peak_total_q;

	logic              tgt_has_right;
	logic [SLOT_W-1:0] rd_slot;
	logic [COL_W-1:0]  rd_col;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;
	logic [VAL_W-1:0]  rdata;
	logic [VAL_W-1:0]  cmp_a;
	logic [VAL_W-1:0]  cmp_b;
	logic              cmp_gt;
	logic              nb_exists;
	logic              out_free;

	always_comb begin
		if (grid_rows_q == '0) begin
			nrows = ROWS_W'(1);
		end else if (grid_rows_q > ROWS_W'(1024)) begin
			nrows = ROWS_W'(1024);
		end else begin
			nrows = grid_rows_q;
		end
		if (grid_cols_q == '0) begin
			ncols = COLS_W'(1);
		end else if (grid_cols_q > COLS_W'(MAX_COLS)) begin
			ncols = COLS_W'(MAX_COLS);
		end else begin
			ncols = grid_cols_q;
		end
	end

	assign tgt_has_right = ((COLS_W + 1)'(tgt_col_q) + (COLS_W + 1)'(1)) <
		(COLS_W + 1)'(ncols);
	assign out_free = !out_valid_q || !out_stall;

	assign sts.has_prev   = (cur_row_q != '0) &&
		((COLS_W + 1)'(cur_col_q) < (COLS_W + 1)'(ncols));
	assign sts.col_last   = !(((COLS_W + 1)'(cur_col_q) + (COLS_W + 1)'(1)) <
		(COLS_W + 1)'(ncols));
	assign sts.row_last   = !((ROWS_W'(cur_row_q) + ROWS_W'(1)) < nrows);
	assign sts.flush_last = !tgt_has_right;
	assign sts.peak_fail  = fail_q;
	assign sts.out_free   = out_free;

	// line store addressing: slot * MAX_COLS + column
	always_comb begin
		rd_slot = tgt_slot_q;
		rd_col  = tgt_col_q;
		case (cmd.rd_sel)
			NB_UP:    rd_slot = slot_prev(tgt_slot_q);
			NB_LEFT:  rd_col  = (tgt_col_q == '0) ? tgt_col_q : tgt_col_q - COL_W'(1);
			NB_RIGHT: rd_col  = (tgt_col_q == COL_MAX) ? tgt_col_q : tgt_col_q + COL_W'(1);
			default:  rd_col  = tgt_col_q;
		endcase
	end

	assign raddr = ADDR_W'(rd_slot) * ADDR_W'(MAX_COLS) + ADDR_W'(rd_col);
	assign waddr = ADDR_W'(cur_slot_q) * ADDR_W'(MAX_COLS) + ADDR_W'(cur_col_q);

	glm4_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (cmd.in_load),
		.waddr (waddr),
		.wdata (cell_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// one signed compare a cycle: neighbour greater than centre
	always_comb begin
		cmp_a     = rdata;
		cmp_b     = ctr_q;
		nb_exists = 1'b0;
		case (cmd.cap_sel)
			NB_CTR: begin
				cmp_a     = down_q;
				cmp_b     = rdata;
				nb_exists = tgt_down_q;
			end
			NB_UP:    nb_exists = (tgt_row_q != '0);
			NB_LEFT:  nb_exists = (tgt_col_q != '0);
			NB_RIGHT: nb_exists = tgt_has_right;
			default:  nb_exists = 1'b0;
		endcase
	end

	assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= ROWS_W'(1);
			grid_cols_q <= COLS_W'(1);
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			cur_slot_q  <= '0;
			peaks_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS: grid_rows_q <= cfg_data[ROWS_W-1:0];
					REG_COLS: grid_cols_q <= cfg_data[COLS_W-1:0];
					default:  grid_rows_q <= grid_rows_q;
				endcase
			end
			if (cmd.adv_col) begin
				cur_col_q <= cur_col_q + COL_W'(1);
			end
			if (cmd.adv_row) begin
				cur_row_q  <= cur_row_q + ROW_W'(1);
				cur_col_q  <= '0;
				cur_slot_q <= slot_next(cur_slot_q);
			end
			if (cmd.emit_peak && (peaks_q != '1)) begin
				peaks_q <= peaks_q + TOT_W'(1);
			end
			if (cmd.frame_clr) begin
				cur_row_q  <= '0;
				cur_col_q  <= '0;
				cur_slot_q <= '0;
				peaks_q    <= '0;
			end
			if (cmd.emit_peak || cmd.emit_sum) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			down_q <= cell_value;
		end
		if (cmd.tgt_in) begin
			tgt_row_q  <= cur_row_q - ROW_W'(1);
			tgt_col_q  <= cur_col_q;
			tgt_slot_q <= slot_prev(cur_slot_q);
			tgt_down_q <= 1'b1;
		end
		if (cmd.tgt_flush) begin
			tgt_row_q  <= cur_row_q;
			tgt_col_q  <= '0;
			tgt_slot_q <= cur_slot_q;
			tgt_down_q <= 1'b0;
		end
		if (cmd.flush_next) begin
			tgt_col_q <= tgt_col_q + COL_W'(1);
		end
		if (cmd.cap_en) begin
			if (cmd.cap_sel == NB_CTR) begin
				ctr_q  <= rdata;
				fail_q <= nb_exists && cmp_gt;
			end else begin
				fail_q <= fail_q || (nb_exists && cmp_gt);
			end
		end
		if (cmd.emit_peak) begin
			peak_value_q <= ctr_q;
			peak_row_q   <= tgt_row_q;
			peak_col_q   <= PCOL_W'(tgt_col_q);
			is_summary_q <= 1'b0;
			peak_total_q <= '0;
		end
		if (cmd.emit_sum) begin
			peak_value_q <= '0;
			peak_row_q   <= '0;
			peak_col_q   <= '0;
			is_summary_q <= 1'b1;
			peak_total_q <= peaks_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign peak_value = peak_value_q;
	assign peak_row   = peak_row_q;
	assign peak_col   = peak_col_q;
	assign is_summary = is_summary_q;
	assign peak_total = peak_total_q;

endmodule

@@ design/grid_local_max_four_neighbour_top.sv @@
// ----------------------------------------------------------------------------
// grid_local_max_four_neighbour_top
// Four-neighbour local maximum detector over a raster grid of signed values.
// ----------------------------------------------------------------------------
// Pacing: an element is taken only while the sequencer is idle. One with no
//   decision due (first row) only advances the position; one that decides the
//   element above it walks the centre, up, left and right reads of the line
//   store's single read port, then any peak waits while the output is stalled.
// Frame end: the last row is decided column by column, then the summary is sent.
// Reset: asynchronous, active low; sizes return to one row by one column and
//   the position and peak count to zero. The line store is not cleared.
// ----------------------------------------------------------------------------
module grid_local_max_four_neighbour_top
	import glm4_pkg::*;
#(
	parameter int MAX_COLS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CDAT_W-1:0] cfg_data,
	// grid element input
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [VAL_W-1:0]  cell_value,
	// result output
	output logic              out_valid,
	input  logic              out_stall,
	output logic [VAL_W-1:0]  peak_value,
	output logic [ROW_W-1:0]  peak_row,
	output logic [PCOL_W-1:0] peak_col,
	output logic              is_summary,
	output logic [TOT_W-1:0]  peak_total
);

	glm4_cmd_t cmd;
	glm4_sts_t sts;

	// Take register writes at any time; user must set sizes only between frames (unchecked).
	assign cfg_ready = 1'b1;

	// Sequencer: hold off new items while the position advances or a decision or the flush runs.
	glm4_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: line store of three rows, comparator, counters, output item.
	// The output register parts the sides, so the next item can be taken
	// while the last result of the previous one still waits.
	glm4_dpath #(
		.MAX_COLS (MAX_COLS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cell_value (cell_value),
		.cmd        (cmd),
		.sts        (sts),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.peak_value (peak_value),
		.peak_row   (peak_row),
		.peak_col   (peak_col),
		.is_summary (is_summary),
		.peak_total (peak_total)
	);

endmodule

@@ bench/grid_local_max_four_neighbour_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_local_max_four_neighbour_top_tb
// Streams signed grid frames into the local maximum detector, predicts every
// peak and frame summary in step with the accepted items, and checks each
// result item field by field as it leaves the block.
// ----------------------------------------------------------------------------
module grid_local_max_four_neighbour_top_tb
	import glm4_pkg::*;
;

	localparam int MAX_COLS    = 32;
	localparam int HOLD_CYCLES = 300;      // long receiver hold-off
	localparam int SETTLE_WAIT = 40;       // quiet cycles before a register write
	localparam int CYCLE_LIMIT = 500000;

	// one result item as the block presents it
	typedef struct {
		logic [VAL_W-1:0]  value;
		logic [ROW_W-1:0]  row;
		logic [PCOL_W-1:0] col;
		logic              summary;
		logic [TOT_W-1:0]  total;
	} peak_item_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CIDX_W-1:0] cfg_index = REG_ROWS;
	logic [CDAT_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [VAL_W-1:0]  cell_value = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [VAL_W-1:0]  peak_value;
	logic [ROW_W-1:0]  peak_row;
	logic [PCOL_W-1:0] peak_col;
	logic              is_summary;
	logic [TOT_W-1:0]  peak_total;

	grid_local_max_four_neighbour_top #(
		.MAX_COLS(MAX_COLS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cell_value(cell_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.peak_value(peak_value),
		.peak_row(peak_row),
		.peak_col(peak_col),
		.is_summary(is_summary),
		.peak_total(peak_total)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// Shadow of the detector: size registers, three-row line buffer,
	// raster position and the running peak count of the frame.
	// ------------------------------------------------------------------------
	logic [ROWS_W-1:0]       rows_reg = 1;
	logic [COLS_W-1:0]       cols_reg = 1;
	logic signed [VAL_W-1:0] line_buf [3][MAX_COLS];
	int                      pos_row = 0;
	int                      pos_col = 0;
	int                      peak_count = 0;

	logic [VAL_W-1:0] cells_to_send [$];   // items waiting for the driver
	peak_item_t       peaks_due [$];       // results owed by the block, oldest first

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;
	int hold_left = 0;
	logic hold_start = 1'b0;
	int cycle_count = 0;

	// A zero register means one; oversize values clamp to the largest grid.
	function automatic int rows_in_use();
		if (rows_reg == 0) return 1;
		if (rows_reg > 1024) return 1024;
		return int'(rows_reg);
	endfunction

	function automatic int cols_in_use();
		if (cols_reg == 0) return 1;
		if (cols_reg > MAX_COLS) return MAX_COLS;
		return int'(cols_reg);
	endfunction

	// Decide element (r, j): it is a peak unless an existing neighbour is
	// strictly greater, so ties pass. Owe a peak item if it passes.
	function automatic void judge_cell(input int r, input int j, input int ncols,
			input bit has_down, input logic signed [VAL_W-1:0] down);
		logic signed [VAL_W-1:0] centre;
		bit         pass;
		peak_item_t hit;
		centre = line_buf[r % 3][j];
		pass = 1'b1;
		if (r > 0 && centre < line_buf[(r - 1) % 3][j]) pass = 1'b0;
		if (has_down && centre < down) pass = 1'b0;
		if (j > 0 && centre < line_buf[r % 3][j - 1]) pass = 1'b0;
		if (j + 1 < ncols && centre < line_buf[r % 3][j + 1]) pass = 1'b0;
		if (pass) begin
			hit.value = centre;
			hit.row = r[ROW_W-1:0];
			hit.col = j[PCOL_W-1:0];
			hit.summary = 1'b0;
			hit.total = '0;
			peaks_due.push_back(hit);
			if (peak_count < 65535) peak_count++;
		end
	endfunction

	// Take one accepted element: store it, decide the element above it, and
	// on the frame's last element flush the bottom row and owe the summary.
	function automatic void take_cell(input logic signed [VAL_W-1:0] v);
		int         nrows;
		int         ncols;
		int         r;
		int         c;
		peak_item_t tail;
		nrows = rows_in_use();
		ncols = cols_in_use();
		r = pos_row;
		c = pos_col;
		if (c < MAX_COLS) line_buf[r % 3][c] = v;
		if (r > 0 && c < ncols) judge_cell(r - 1, c, ncols, 1'b1, v);
		if (c + 1 < ncols) begin
			pos_col = c + 1;
			return;
		end
		if (r + 1 < nrows) begin
			pos_row = r + 1;
			pos_col = 0;
			return;
		end
		for (int j = 0; j < ncols; j++) judge_cell(r, j, ncols, 1'b0, '0);
		tail.value = '0;
		tail.row = '0;
		tail.col = '0;
		tail.summary = 1'b1;
		tail.total = peak_count[TOT_W-1:0];
		peaks_due.push_back(tail);
		pos_row = 0;
		pos_col = 0;
		peak_count = 0;
	endfunction

	task automatic flag_mismatch(input string what);
		if (mismatch_count < 100) $display("%0t mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------------
	// Driver: hold an offered item until it is taken, then either offer the
	// next pending item or idle at the current sender rate.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) take_cell(cell_value);
			if (!in_valid || !in_stall) begin
				if (cells_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					cell_value <= cells_to_send.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long hold-off of the receiver, counted here so that the stimulus
	// process only has to start it.
	always @(posedge clk) begin
		if (hold_start) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: compare every taken result item with the oldest one owed,
	// then choose whether to stall the next cycle.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_watch
		peak_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (peaks_due.size() == 0) begin
				flag_mismatch($sformatf("unowed item value %h row %0d col %0d summary %0b total %0d",
					peak_value, peak_row, peak_col, is_summary, peak_total));
			end else begin
				want = peaks_due.pop_front();
				if (is_summary !== want.summary)
					flag_mismatch($sformatf("is_summary got %b want %b (row %0d col %0d)",
						is_summary, want.summary, want.row, want.col));
				if (peak_value !== want.value)
					flag_mismatch($sformatf("peak_value got %h want %h (row %0d col %0d)",
						peak_value, want.value, want.row, want.col));
				if (peak_row !== want.row)
					flag_mismatch($sformatf("peak_row got %0d want %0d", peak_row, want.row));
				if (peak_col !== want.col)
					flag_mismatch($sformatf("peak_col got %0d want %0d (row %0d)",
						peak_col, want.col, want.row));
				if (peak_total !== want.total)
					flag_mismatch($sformatf("peak_total got %0d want %0d",
						peak_total, want.total));
			end
		end
		out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
	end

	// Hard stop: the slowest correct run stays far below this.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Write one size register and mirror it once the write is taken.
	task automatic write_size_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_ROWS) begin
			rows_reg = data;
		end else begin
			cols_reg = data[COLS_W-1:0];
		end
		@(negedge clk);
	endtask

	// Hold the sender until every owed result has come, then give the block
	// time to finish an item that owes nothing.
	task automatic settle_block();
		while (cells_to_send.size() != 0 || in_valid || peaks_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_WAIT) @(negedge clk);
	endtask

	// Two in five values tiny so that ties and plateaus are common, the rest full
	// range with a share of the extremes.
	function automatic logic [VAL_W-1:0] pick_cell();
		int mode;
		mode = $urandom_range(99);
		if (mode < 40) return $urandom_range(2) - 1;
		if (mode < 85) return $urandom;
		case ($urandom_range(3))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	task automatic queue_cells(input int count);
		for (int i = 0; i < count; i++) cells_to_send.push_back(pick_cell());
	endtask

	task automatic start_hold();
		@(negedge clk);
		hold_start = 1'b1;
		@(negedge clk);
		hold_start = 1'b0;
	endtask

	// Whole frames of random shape; now and then resize between frames,
	// otherwise run frames back to back with no pause.
	task automatic random_phase(input int send_pct, input int recv_pct, input int goal);
		int                queued;
		logic [ROWS_W-1:0] rows_pick;
		logic [COLS_W-1:0] cols_pick;
		logic [CDAT_W-1:0] cols_word;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		queued = 0;
		while (queued < goal) begin
			if (queued == 0 || $urandom_range(1) == 1) begin
				settle_block();
				case ($urandom_range(9))
					0: cols_pick = 6'd0;
					1: cols_pick = 6'd1;
					2: cols_pick = 6'd32;
					3: cols_pick = 6'($urandom_range(63, 33));
					default: cols_pick = 6'($urandom_range(8, 2));
				endcase
				if (cols_pick >= MAX_COLS) begin
					rows_pick = 11'($urandom_range(2));
				end else begin
					case ($urandom_range(9))
						0: rows_pick = 11'd0;
						1: rows_pick = 11'd1;
						default: rows_pick = 11'($urandom_range(6, 2));
					endcase
				end
				// spare upper data bits must not reach the column register
				cols_word = 11'($urandom_range(2047));
				cols_word[COLS_W-1:0] = cols_pick;
				write_size_reg(REG_ROWS, rows_pick);
				write_size_reg(REG_COLS, cols_word);
			end
			queue_cells(rows_in_use() * cols_in_use());
			queued += rows_in_use() * cols_in_use();
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		logic [VAL_W-1:0] corner_grid [9];
		corner_grid = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF,
			32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF};

		// reset once, released on a clock edge
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 25;
		recv_idle_pct = 48;

		// reset sizes: a one-by-one grid, smallest value is its own peak
		cells_to_send.push_back(32'h8000_0000);
		settle_block();

		// zero registers behave as one row and one column
		write_size_reg(REG_ROWS, 11'd0);
		write_size_reg(REG_COLS, 11'd0);
		cells_to_send.push_back(32'h7FFF_FFFF);
		settle_block();

		// three by three with extremes, equal neighbours and corners
		write_size_reg(REG_ROWS, 11'd3);
		write_size_reg(REG_COLS, 11'd3);
		foreach (corner_grid[i]) cells_to_send.push_back(corner_grid[i]);
		settle_block();

		// resize in mid frame: narrow the grid while the position already sits
		// on the new last column, then cut the rows while past the new last row
		write_size_reg(REG_ROWS, 11'd4);
		write_size_reg(REG_COLS, 11'd4);
		queue_cells(9);
		settle_block();
		write_size_reg(REG_COLS, 11'h7C2);
		queue_cells(1);
		settle_block();
		write_size_reg(REG_ROWS, 11'd2);
		queue_cells(2);
		settle_block();

		// back-pressure: keep offering a large frame while the receiver
		// holds off, so that the block fills and stalls its input
		write_size_reg(REG_ROWS, 11'd6);
		write_size_reg(REG_COLS, 11'd8);
		queue_cells(48);
		start_hold();
		settle_block();

		random_phase(25, 48, 55);
		random_phase(48, 25, 55);
		random_phase(0, 0, 55);

		// oversize row register acts as the tallest grid: four rows of one
		// column leave the frame open, then cutting the rows ends it
		settle_block();
		write_size_reg(REG_ROWS, 11'd2047);
		write_size_reg(REG_COLS, 11'd1);
		queue_cells(4);
		settle_block();
		write_size_reg(REG_ROWS, 11'd2);
		queue_cells(1);

		settle_block();
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
